[hw/rtl/ult_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ult_pkg
// Command and status codes and the cell control word of the list table.
// ----------------------------------------------------------------------------
package ult_pkg;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_DELETE    = 3'd1;
  localparam logic [2:0] CMD_LOOKUP    = 3'd2;
  localparam logic [2:0] CMD_ITER_RST  = 3'd3;
  localparam logic [2:0] CMD_NEXT      = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_NO_NEXT    = 2'd3;

  typedef struct packed {
    logic cmp;  // compare incoming word against stored entry
    logic ins;  // shift toward tail, cell 0 takes the new value
    logic del;  // cells at or past the first match take from the tail side
  } cell_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/ult_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ult_cell
// One entry slot: holds a value, compares it, shifts with its neighbors and
// forwards the match and iterator read chains.
// ----------------------------------------------------------------------------
module ult_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  wire                     clk,
  input  wire ult_pkg::cell_ctl_t ctl,
  input  wire  [DATA_WIDTH-1:0]   value,
  input  wire  [CNT_W-1:0]        count,
  input  wire  [CNT_W-1:0]        iter_pos,
  input  wire  [DATA_WIDTH-1:0]   prev_entry,
  input  wire  [DATA_WIDTH-1:0]   next_entry,
  input  wire                     seen_in,
  input  wire  [DATA_WIDTH-1:0]   rd_in,
  input  wire                     iter_hit_in,
  output logic [DATA_WIDTH-1:0]   entry,
  output logic                    seen_out,
  output logic [DATA_WIDTH-1:0]   rd_out,
  output logic                    iter_hit_out
);

  localparam logic [CNT_W-1:0] POS  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] POS1 = CNT_W'(INDEX + 1);

  logic hit;
  logic live;

  assign live         = (POS < count);
  assign seen_out     = seen_in | hit;
  assign rd_out       = rd_in | ((iter_pos == POS) ? entry : '0);
  assign iter_hit_out = iter_hit_in | ((iter_pos == POS1) & seen_out);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= live && (entry == value);
    end
    if (ctl.ins) begin
      entry <= prev_entry;
    end else if (ctl.del && seen_out) begin
      entry <= next_entry;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/unsorted_list_table_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// unsorted_list_table_unit
// Newest-first list of up to DEPTH values with insert, delete, lookup and an
// iterator, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// When a word is accepted every cell compares its entry against the value,
// and in the execute state that follows the cells shift (insert) or compact
// (delete) in place while the result word is registered. The execute state
// waits while a previous result is still held on the output.
// Entries are undefined after reset; only the first entry_count are ever read.
// ----------------------------------------------------------------------------
module unsorted_list_table_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_ready,
  input  wire  [2:0]             command,
  input  wire  [DATA_WIDTH-1:0]  value,
  output logic                   result_valid,
  input  wire                    result_ready,
  output logic [1:0]             status,
  output logic [DATA_WIDTH-1:0]  data,
  output logic [CNT_W-1:0]       entry_count,
  output logic                   is_empty,
  output logic                   has_next
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

  logic                  state;
  logic [2:0]            cmd_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      iter_pos;

  logic                  exe_go;
  logic                  ins;
  logic                  del;
  logic [1:0]            status_next;
  logic [DATA_WIDTH-1:0] data_next;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      iter_next;
  ult_pkg::cell_ctl_t    ctl;

  logic [DATA_WIDTH-1:0] entry_w [DEPTH];
  logic [DEPTH:0]        seen_w;
  logic [DEPTH:0]        ihit_w;
  logic [DATA_WIDTH-1:0] rd_w    [DEPTH+1];

  assign item_ready = (state == S_IDLE);
  assign exe_go     = (state == S_EXEC) && (!result_valid || result_ready);

  assign ctl.cmp = item_valid && item_ready;
  assign ctl.ins = ins && exe_go;
  assign ctl.del = del && exe_go;

  assign seen_w[0] = 1'b0;
  assign ihit_w[0] = 1'b0;
  assign rd_w[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_e;
    logic [DATA_WIDTH-1:0] next_e;
    if (i == 0) begin : g_head
      assign prev_e = value_q;
    end else begin : g_mid_p
      assign prev_e = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid_n
      assign next_e = entry_w[i+1];
    end
    ult_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .value        (value),
      .count        (count),
      .iter_pos     (iter_pos),
      .prev_entry   (prev_e),
      .next_entry   (next_e),
      .seen_in      (seen_w[i]),
      .rd_in        (rd_w[i]),
      .iter_hit_in  (ihit_w[i]),
      .entry        (entry_w[i]),
      .seen_out     (seen_w[i+1]),
      .rd_out       (rd_w[i+1]),
      .iter_hit_out (ihit_w[i+1])
    );
  end

  always_comb begin
    status_next = ult_pkg::ST_OK;
    data_next   = value_q;
    count_next  = count;
    iter_next   = iter_pos;
    ins         = 1'b0;
    del         = 1'b0;
    unique case (cmd_q)
      ult_pkg::CMD_INSERT: begin
        if (count == FULL_COUNT) begin
          status_next = ult_pkg::ST_FULL;
        end else begin
          ins        = 1'b1;
          count_next = count + ONE;
          if (iter_pos != '0) begin
            iter_next = iter_pos + ONE;
          end
        end
      end
      ult_pkg::CMD_DELETE: begin
        if (!seen_w[DEPTH]) begin
          status_next = ult_pkg::ST_NOT_FOUND;
        end else begin
          del        = 1'b1;
          count_next = count - ONE;
          if (ihit_w[DEPTH]) begin
            iter_next = iter_pos - ONE;
          end
        end
      end
      ult_pkg::CMD_LOOKUP: begin
        if (!seen_w[DEPTH]) begin
          status_next = ult_pkg::ST_NOT_FOUND;
        end
      end
      ult_pkg::CMD_ITER_RST: begin
        iter_next = '0;
      end
      ult_pkg::CMD_NEXT: begin
        if (iter_pos < count) begin
          iter_next = iter_pos + ONE;
          data_next = rd_w[DEPTH];
        end else begin
          status_next = ult_pkg::ST_NO_NEXT;
        end
      end
      ult_pkg::CMD_CLEAR: begin
        count_next = '0;
        iter_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      count        <= '0;
      iter_pos     <= '0;
    end else begin
      if (ctl.cmp) begin
        state <= S_EXEC;
      end
      if (exe_go) begin
        state        <= S_IDLE;
        count        <= count_next;
        iter_pos     <= iter_next;
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      cmd_q   <= command;
      value_q <= value;
    end
    if (exe_go) begin
      status      <= status_next;
      data        <= data_next;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      has_next    <= (iter_next < count_next);
    end
  end

endmodule
`default_nettype wire
